// File: sv/keyboard_host_command_responder_defines.svh
// assertion macros shared by the keyboard host command responder rtl
`ifndef KEYBOARD_HOST_COMMAND_RESPONDER_DEFINES_SVH
`define KEYBOARD_HOST_COMMAND_RESPONDER_DEFINES_SVH
`ifndef SYNTH
`define KHCR_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("khcr check failed");
`define KHCR_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("khcr check failed");
`else
`define KHCR_ASSERT_IMP(label, ante, cons)
`define KHCR_ASSERT_NXT(label, ante, cons)
`endif
`endif

// File: sv/khcr_pkg.sv
// types and constants of the keyboard host command responder
`timescale 1ns / 1ps
`default_nettype none
package khcr_pkg;

	// host command codes
	localparam logic [7:0] CMD_RESET        = 8'hFF;
	localparam logic [7:0] CMD_RESEND       = 8'hFE;
	localparam logic [7:0] CMD_RSVD_FD      = 8'hFD;
	localparam logic [7:0] CMD_RSVD_FC      = 8'hFC;
	localparam logic [7:0] CMD_RSVD_FB      = 8'hFB;
	localparam logic [7:0] CMD_ALL_TM_BRK   = 8'hFA;
	localparam logic [7:0] CMD_ALL_MAKE     = 8'hF9;
	localparam logic [7:0] CMD_ALL_MK_BRK   = 8'hF8;
	localparam logic [7:0] CMD_ALL_TM       = 8'hF7;
	localparam logic [7:0] CMD_SET_DEFAULT  = 8'hF6;
	localparam logic [7:0] CMD_DISABLE      = 8'hF5;
	localparam logic [7:0] CMD_ENABLE       = 8'hF4;
	localparam logic [7:0] CMD_TYPEMATIC    = 8'hF3;
	localparam logic [7:0] CMD_READ_ID      = 8'hF2;
	localparam logic [7:0] CMD_SCAN_SET     = 8'hF0;
	localparam logic [7:0] CMD_ECHO         = 8'hEE;
	localparam logic [7:0] CMD_SET_LEDS     = 8'hED;

	// response bytes
	localparam logic [7:0] RSP_SELF_TEST = 8'hAA;
	localparam logic [7:0] RSP_ACK       = 8'hFA;
	localparam logic [7:0] RSP_NAK       = 8'hFE;
	localparam logic [7:0] RSP_ID_LO     = 8'hAB;
	localparam logic [7:0] RSP_ID_HI     = 8'h83;
	localparam logic [7:0] RSP_ECHO      = 8'hEE;
	localparam logic [7:0] RSP_SET1      = 8'h43;
	localparam logic [7:0] RSP_SET2      = 8'h41;
	localparam logic [7:0] RSP_SET3      = 8'h3F;

	localparam logic [6:0] DEFAULT_RATE_DELAY = 7'h1B;
	localparam logic [1:0] DEFAULT_SET_IDX    = 2'd2;

	localparam int RSP_MAX = 3;
	localparam int M_TDATA_W = 32;

	// settings reported with every result
	typedef struct packed {
		logic       awaiting;
		logic       scan_en;
		logic [6:0] rate_delay;
		logic [1:0] set_idx;
		logic [7:0] leds;
		logic       typ_all;
		logic       brk_all;
	} settings_t;

	// full keyboard state
	typedef struct packed {
		settings_t  set;
		logic [7:0] pending_cmd;
		logic [7:0] last_sent;
	} kbd_state_t;

	// response group for one request
	typedef struct packed {
		logic                    status;
		logic [1:0]              cnt;
		logic [RSP_MAX-1:0][7:0] bytes;
		settings_t               set;
	} resp_grp_t;

endpackage
`default_nettype wire

// File: sv/keyboard_host_command_responder.sv
// top level of the keyboard host command responder
`timescale 1ns / 1ps
`default_nettype none
// Keyboard-side responder to host command bytes. Each request on the s_ side
// is either a host byte (a command, or the parameter of a pending f3, f0 or
// ed command) or a status read. A request is answered with zero to three
// result items on the m_ side, one per cycle while m_tready is high, each
// carrying a response byte (fa ack, fe nak, aa, ee, ab 83, or the scan set
// code) and the settings as they stand after the request. Commands f3, f4,
// f5, f6, and f2 while xt_ignore_id is set, are answered with nothing at all.
// A request can be taken every cycle while the output register can take
// the one before it; it waits in the input register, where the decoder
// updates the keyboard state, until the output register is free, and its
// group of results is then sent from the output register at one byte per
// cycle while m_tready is high (three results at most, for the read-id
// reply), while the next request waits in the input register. xt_ignore_id
// may only change while idle.
module keyboard_host_command_responder import khcr_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration: bit 0 xt_ignore_id
	input  logic                 cfg_we,
	input  logic                 cfg_wdata,
	// requests
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [7:0]           s_tdata,   // [7:0] host_byte
	input  logic                 s_tuser,   // [0] kind (1 status read)
	// results
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// [7:0] resp_byte, [8] flush_older, [9] in_command, [10] scanning_on,
	// [17:11] rate_delay, [19:18] scan_set, [27:20] led_bits,
	// [28] all_typematic, [29] all_break, [31:30] zero
	output logic [M_TDATA_W-1:0] m_tdata,
	output logic                 m_tuser,   // [0] resp_valid
	output logic                 m_tlast
);

	localparam kbd_state_t STATE_RST = '{
		set: '{awaiting: 1'b0, scan_en: 1'b1, rate_delay: 7'd0, set_idx: 2'd0,
			leds: 8'd0, typ_all: 1'b1, brk_all: 1'b1},
		pending_cmd: 8'd0,
		last_sent: RSP_SELF_TEST
	};

	logic       xt_ignore_id_q;
	logic       in_valid_s1;
	logic       kind_s1;
	logic [7:0] byte_s1;
	kbd_state_t state_q;
	kbd_state_t state_nx;
	resp_grp_t  grp;
	logic       emit_ready;
	logic       advance;

	// request leaves the input register once the output register can take it
	assign advance  = in_valid_s1 && emit_ready;
	assign s_tready = !in_valid_s1 || emit_ready;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			xt_ignore_id_q <= 1'b0;
		else if (cfg_we)
			xt_ignore_id_q <= cfg_wdata;
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			in_valid_s1 <= 1'b0;
		else if (s_tready)
			in_valid_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			kind_s1 <= s_tuser;
			byte_s1 <= s_tdata;
		end
	end

	// keyboard state, updated as a request is decoded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= STATE_RST;
		else if (advance)
			state_q <= state_nx;
	end

	khcr_decode u_decode (
		.st           (state_q),
		.xt_ignore_id (xt_ignore_id_q),
		.kind         (kind_s1),
		.host_byte    (byte_s1),
		.nx           (state_nx),
		.grp          (grp)
	);

	// silent commands load nothing into the output register
	khcr_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance && (grp.cnt != 2'd0)),
		.grp      (grp),
		.ready    (emit_ready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule
`default_nettype wire

// File: sv/khcr_decode.sv
// command and parameter decoder: next state and response bytes
`timescale 1ns / 1ps
`default_nettype none
module khcr_decode import khcr_pkg::*; (
	input  kbd_state_t st,
	input  logic       xt_ignore_id,
	input  logic       kind,
	input  logic [7:0] host_byte,
	output kbd_state_t nx,
	output resp_grp_t  grp
);

	always_comb begin
		nx        = st;
		grp       = '0;
		grp.status = kind;
		if (kind) begin
			// status read, single empty result
			grp.cnt = 2'd1;
		end else if (st.set.awaiting) begin
			case (st.pending_cmd)
				CMD_TYPEMATIC: begin
					grp.cnt = 2'd1;
					nx.set.awaiting = 1'b0;
					if (!host_byte[7]) begin
						nx.set.rate_delay = host_byte[6:0];
						grp.bytes[0] = RSP_ACK;
					end else begin
						grp.bytes[0] = RSP_NAK;
					end
				end
				CMD_SCAN_SET: begin
					grp.cnt = 2'd1;
					if (host_byte == 8'd0) begin
						// query keeps the command pending
						grp.bytes[0] = RSP_ACK;
						unique case (st.set.set_idx)
							2'd0: begin
								grp.bytes[1] = RSP_SET1;
								grp.cnt = 2'd2;
							end
							2'd1: begin
								grp.bytes[1] = RSP_SET2;
								grp.cnt = 2'd2;
							end
							2'd2: begin
								grp.bytes[1] = RSP_SET3;
								grp.cnt = 2'd2;
							end
							default: ;
						endcase
					end else if (host_byte < 8'd4) begin
						nx.set.set_idx = host_byte[1:0] - 2'd1;
						nx.set.awaiting = 1'b0;
						grp.bytes[0] = RSP_ACK;
					end else begin
						nx.set.awaiting = 1'b0;
						grp.bytes[0] = RSP_NAK;
					end
				end
				CMD_SET_LEDS: begin
					nx.set.leds = host_byte;
					nx.set.awaiting = 1'b0;
					grp.bytes[0] = RSP_ACK;
					grp.cnt = 2'd1;
				end
				default: ;
			endcase
		end else begin
			nx.set.awaiting = 1'b0;
			nx.pending_cmd = host_byte;
			unique case (host_byte) inside
				CMD_RESET: begin
					nx.pending_cmd    = '0;
					nx.set.rate_delay = '0;
					nx.set.set_idx    = '0;
					nx.set.scan_en    = 1'b1;
					nx.set.leds       = '0;
					nx.last_sent      = RSP_SELF_TEST;
					grp.bytes[0]      = RSP_SELF_TEST;
					grp.cnt           = 2'd1;
				end
				CMD_RESEND: begin
					grp.bytes[0] = st.last_sent;
					grp.cnt = 2'd1;
				end
				CMD_ALL_TM_BRK, CMD_ALL_MAKE, CMD_ALL_MK_BRK, CMD_ALL_TM: begin
					grp.bytes[0] = RSP_ACK;
					grp.cnt = 2'd1;
					nx.set.typ_all = (host_byte == CMD_ALL_TM_BRK) ||
						(host_byte == CMD_ALL_TM);
					nx.set.brk_all = (host_byte == CMD_ALL_TM_BRK) ||
						(host_byte == CMD_ALL_MK_BRK);
				end
				CMD_SET_DEFAULT, CMD_DISABLE: begin
					if (host_byte == CMD_DISABLE)
						nx.set.scan_en = 1'b0;
					nx.set.typ_all    = 1'b1;
					nx.set.brk_all    = 1'b1;
					nx.set.rate_delay = DEFAULT_RATE_DELAY;
					nx.set.set_idx    = DEFAULT_SET_IDX;
				end
				CMD_ENABLE: nx.set.scan_en = 1'b1;
				CMD_TYPEMATIC: nx.set.awaiting = 1'b1;
				CMD_READ_ID: begin
					if (!xt_ignore_id) begin
						grp.bytes[0] = RSP_ACK;
						grp.bytes[1] = RSP_ID_LO;
						grp.bytes[2] = RSP_ID_HI;
						grp.cnt = 2'd3;
					end
				end
				CMD_SCAN_SET, CMD_SET_LEDS: begin
					grp.bytes[0] = RSP_ACK;
					grp.cnt = 2'd1;
					nx.set.awaiting = 1'b1;
				end
				CMD_ECHO: begin
					grp.bytes[0] = RSP_ECHO;
					grp.cnt = 2'd1;
				end
				default: begin
					// unknown commands and the reserved fb..fd
					grp.bytes[0] = RSP_NAK;
					grp.cnt = 2'd1;
				end
			endcase
		end
		grp.set = nx.set;
	end

endmodule
`default_nettype wire

// File: sv/khcr_emit.sv
// result register that sends a response group one byte per cycle while m_tready is high
`timescale 1ns / 1ps
`default_nettype none
`include "keyboard_host_command_responder_defines.svh"
module khcr_emit import khcr_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  resp_grp_t            grp,
	output logic                 ready,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,
	output logic                 m_tuser,
	output logic                 m_tlast
);

	logic      busy_q;
	logic [1:0] idx_q;
	resp_grp_t grp_q;
	logic      is_last;
	logic      take;
	logic      flush;

	assign is_last = (idx_q == grp_q.cnt - 2'd1);
	assign take    = busy_q && m_tready;
	assign ready   = !busy_q || (take && is_last);
	assign flush   = !grp_q.status && (idx_q == 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (take) begin
			if (is_last)
				busy_q <= 1'b0;
			else
				idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			grp_q <= grp;
	end

	assign m_tvalid = busy_q;
	assign m_tuser  = !grp_q.status;
	assign m_tlast  = is_last;
	assign m_tdata  = {2'b00, grp_q.set.brk_all, grp_q.set.typ_all, grp_q.set.leds,
		grp_q.set.set_idx, grp_q.set.rate_delay, grp_q.set.scan_en,
		grp_q.set.awaiting, flush, grp_q.bytes[idx_q]};

	`KHCR_ASSERT_IMP(a_idx_in_group, busy_q, (idx_q < grp_q.cnt))
	`KHCR_ASSERT_IMP(a_status_single, busy_q && grp_q.status, (grp_q.cnt == 2'd1))
	`KHCR_ASSERT_IMP(a_load_when_free, load, ready && (grp.cnt != 2'd0))
	`KHCR_ASSERT_NXT(a_drain_idle, take && is_last && !load, !busy_q)

endmodule
`default_nettype wire

// File: verif/keyboard_host_command_responder_tb.sv
// testbench of the keyboard host command responder, self-checking against its own predictor
`timescale 1ns / 1ps
module keyboard_host_command_responder_tb;
	import khcr_pkg::*;

	// run bounds
	localparam int CYCLE_LIMIT   = 200000;
	localparam int SETTLE_CYCLES = 8;        // request register plus output register, with margin
	localparam int PHASE_ITEMS   = 90;

	// typematic parameters with bit 7 set are refused, scan set parameters above 3 too
	localparam logic [7:0] TYPEMATIC_BAD = 8'h80;
	localparam logic [7:0] SCAN_SET_MAX  = 8'h03;
	localparam logic [7:0] SCAN_SET_QRY  = 8'h00;

	// one byte sent back to the host, with the settings after its request
	typedef struct {
		bit         resp_valid;
		logic [7:0] resp_byte;
		bit         flush_older;
		bit         is_last;
		settings_t  st;
	} kbd_reply_t;

	// clock and reset
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	// block inputs, known from time zero
	logic       cfg_we    = 1'b0;
	logic       cfg_wdata = 1'b0;
	logic       s_tvalid  = 1'b0;
	logic [7:0] s_tdata   = 8'h00;
	logic       s_tuser   = 1'b0;
	logic       m_tready  = 1'b0;

	// block outputs
	logic                 s_tready;
	logic                 m_tvalid;
	logic [M_TDATA_W-1:0] m_tdata;
	logic                 m_tuser;
	logic                 m_tlast;

	// predicted keyboard state
	settings_t  kbd;
	logic [7:0] kbd_pending;
	logic [7:0] kbd_last_sent;
	bit         xt_ignore_id;

	kbd_reply_t expected_replies[$];

	int tx_idle_pct;
	int rx_idle_pct;
	int requests_sent;
	int status_reads;
	int replies_checked;
	int error_count;
	int cycle_count;

	// commands drawn for well-formed random sequences
	logic [7:0] command_menu [17] = '{
		CMD_RESET, CMD_RESEND, CMD_RSVD_FD, CMD_RSVD_FC, CMD_RSVD_FB, CMD_ALL_TM_BRK,
		CMD_ALL_MAKE, CMD_ALL_MK_BRK, CMD_ALL_TM, CMD_SET_DEFAULT, CMD_DISABLE,
		CMD_ENABLE, CMD_TYPEMATIC, CMD_READ_ID, CMD_SCAN_SET, CMD_ECHO, CMD_SET_LEDS
	};

	keyboard_host_command_responder i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// 12 ns period
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// receiver back-pressure
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= rx_idle_pct);
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t watchdog expired with %0d replies outstanding", $time,
				expected_replies.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// works out the replies of one accepted request and queues them
	task automatic predict_keyboard_reply(input bit is_status, input logic [7:0] hb);
		logic [7:0] answer[$];
		kbd_reply_t r;
		if (is_status) begin
			r.resp_valid  = 1'b0;
			r.resp_byte   = 8'h00;
			r.flush_older = 1'b0;
			r.is_last     = 1'b1;
			r.st          = kbd;
			expected_replies.push_back(r);
			return;
		end
		if (kbd.awaiting) begin
			// parameter byte of the pending command
			case (kbd_pending)
				CMD_TYPEMATIC: begin
					if (hb < TYPEMATIC_BAD) begin
						kbd.rate_delay = hb[6:0];
						answer.push_back(RSP_ACK);
					end else begin
						answer.push_back(RSP_NAK);
					end
					kbd.awaiting = 1'b0;
				end
				CMD_SCAN_SET: begin
					if (hb == SCAN_SET_QRY) begin
						// query keeps the command pending
						answer.push_back(RSP_ACK);
						case (kbd.set_idx)
							2'd0: answer.push_back(RSP_SET1);
							2'd1: answer.push_back(RSP_SET2);
							2'd2: answer.push_back(RSP_SET3);
							default: ;
						endcase
					end else begin
						if (hb <= SCAN_SET_MAX) begin
							kbd.set_idx = hb[1:0] - 2'd1;
							answer.push_back(RSP_ACK);
						end else begin
							answer.push_back(RSP_NAK);
						end
						kbd.awaiting = 1'b0;
					end
				end
				CMD_SET_LEDS: begin
					kbd.leds     = hb;
					kbd.awaiting = 1'b0;
					answer.push_back(RSP_ACK);
				end
				default: ;
			endcase
		end else begin
			kbd.awaiting = 1'b0;
			kbd_pending  = hb;
			case (hb)
				CMD_RESET: begin
					// mode-3 flags survive the reset command
					kbd_pending    = 8'h00;
					kbd.rate_delay = '0;
					kbd.set_idx    = '0;
					kbd.scan_en    = 1'b1;
					kbd.leds       = 8'h00;
					kbd_last_sent  = RSP_SELF_TEST;
					answer.push_back(RSP_SELF_TEST);
				end
				CMD_RESEND: answer.push_back(kbd_last_sent);
				CMD_RSVD_FD, CMD_RSVD_FC, CMD_RSVD_FB: answer.push_back(RSP_NAK);
				CMD_ALL_TM_BRK: begin
					answer.push_back(RSP_ACK);
					kbd.typ_all = 1'b1;
					kbd.brk_all = 1'b1;
				end
				CMD_ALL_MAKE: begin
					answer.push_back(RSP_ACK);
					kbd.typ_all = 1'b0;
					kbd.brk_all = 1'b0;
				end
				CMD_ALL_MK_BRK: begin
					answer.push_back(RSP_ACK);
					kbd.typ_all = 1'b0;
					kbd.brk_all = 1'b1;
				end
				CMD_ALL_TM: begin
					answer.push_back(RSP_ACK);
					kbd.typ_all = 1'b1;
					kbd.brk_all = 1'b0;
				end
				CMD_SET_DEFAULT, CMD_DISABLE: begin
					// no ack on either, disable also stops scanning
					if (hb == CMD_DISABLE)
						kbd.scan_en = 1'b0;
					kbd.typ_all    = 1'b1;
					kbd.brk_all    = 1'b1;
					kbd.rate_delay = DEFAULT_RATE_DELAY;
					kbd.set_idx    = DEFAULT_SET_IDX;
				end
				CMD_ENABLE:    kbd.scan_en = 1'b1;
				CMD_TYPEMATIC: kbd.awaiting = 1'b1;
				CMD_READ_ID: begin
					if (!xt_ignore_id) begin
						answer.push_back(RSP_ACK);
						answer.push_back(RSP_ID_LO);
						answer.push_back(RSP_ID_HI);
					end
				end
				CMD_SCAN_SET, CMD_SET_LEDS: begin
					answer.push_back(RSP_ACK);
					kbd.awaiting = 1'b1;
				end
				CMD_ECHO: answer.push_back(RSP_ECHO);
				default:  answer.push_back(RSP_NAK);
			endcase
		end
		foreach (answer[k]) begin
			r.resp_valid  = 1'b1;
			r.resp_byte   = answer[k];
			r.flush_older = (k == 0);
			r.is_last     = (k == answer.size() - 1);
			r.st          = kbd;
			expected_replies.push_back(r);
		end
	endtask

	function automatic void compare_field(input string name, input int exp_v, input int act_v);
		if (exp_v != act_v) begin
			$display("%0t %s mismatch: expected %0h, actual %0h", $time, name, exp_v, act_v);
			error_count++;
		end
	endfunction

	// one reply seen on the result side
	task automatic check_reply();
		kbd_reply_t e;
		if (expected_replies.size() == 0) begin
			$display("%0t unexpected reply: expected none, actual tdata %0h tuser %0b tlast %0b",
				$time, m_tdata, m_tuser, m_tlast);
			error_count++;
			return;
		end
		e = expected_replies.pop_front();
		replies_checked++;
		compare_field("resp_valid",    e.resp_valid,    m_tuser);
		compare_field("resp_byte",     e.resp_byte,     m_tdata[7:0]);
		compare_field("flush_older",   e.flush_older,   m_tdata[8]);
		compare_field("in_command",    e.st.awaiting,   m_tdata[9]);
		compare_field("scanning_on",   e.st.scan_en,    m_tdata[10]);
		compare_field("rate_delay",    e.st.rate_delay, m_tdata[17:11]);
		compare_field("scan_set",      e.st.set_idx,    m_tdata[19:18]);
		compare_field("led_bits",      e.st.leds,       m_tdata[27:20]);
		compare_field("all_typematic", e.st.typ_all,    m_tdata[28]);
		compare_field("all_break",     e.st.brk_all,    m_tdata[29]);
		compare_field("tdata padding", 0,               m_tdata[31:30]);
		compare_field("last",          e.is_last,       m_tlast);
	endtask

	// outputs are stable at the falling edge, so a handshake seen here completes at the next rise
	always @(negedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			check_reply();
	end

	// presents one request and waits until it is taken
	task automatic send_request(input bit is_status, input logic [7:0] hb);
		bit taken;
		if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= is_status;
		// the byte is don't-care on a status read, so exercise its bits there as well
		s_tdata  <= is_status ? 8'($urandom_range(255)) : hb;
		do begin
			@(negedge clk);
			taken = s_tready;
			@(posedge clk);
		end while (!taken);
		predict_keyboard_reply(is_status, hb);
		requests_sent++;
		if (is_status)
			status_reads++;
	endtask

	// sender holds off until every reply is back and the pipeline has emptied
	task automatic wait_for_replies();
		s_tvalid <= 1'b0;
		while (expected_replies.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// register write, only ever made with the block idle
	task automatic write_xt_ignore(input bit value);
		wait_for_replies();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		xt_ignore_id = value;
	endtask

	// reset state read back, echo, resend, unknown and reserved commands
	task automatic test_status_echo_resend();
		send_request(1'b1, 8'h00);
		send_request(1'b0, CMD_ECHO);
		send_request(1'b0, CMD_RESEND);
		send_request(1'b0, 8'h00);
		send_request(1'b0, CMD_RSVD_FD);
	endtask

	// typematic setting at its top value, then a refused parameter
	task automatic test_typematic_rate();
		send_request(1'b0, CMD_TYPEMATIC);
		send_request(1'b0, 8'h7F);
		send_request(1'b0, CMD_TYPEMATIC);
		send_request(1'b0, 8'hFF);
	endtask

	// query keeps f0 pending, so the next byte selects the set
	task automatic test_scan_set();
		send_request(1'b0, CMD_SCAN_SET);
		send_request(1'b0, SCAN_SET_QRY);
		send_request(1'b0, SCAN_SET_MAX);
		send_request(1'b0, CMD_SCAN_SET);
		send_request(1'b0, SCAN_SET_QRY);
		send_request(1'b0, 8'h04);
	endtask

	// led byte and the four all-keys commands
	task automatic test_leds_and_mode3();
		send_request(1'b0, CMD_SET_LEDS);
		send_request(1'b0, 8'hFF);
		send_request(1'b0, CMD_ALL_MAKE);
		send_request(1'b0, CMD_ALL_MK_BRK);
		send_request(1'b0, CMD_ALL_TM);
		send_request(1'b0, CMD_ALL_TM_BRK);
	endtask

	// silent commands first, then the reset command
	task automatic test_defaults_and_reset();
		send_request(1'b0, CMD_DISABLE);
		send_request(1'b0, CMD_ENABLE);
		send_request(1'b0, CMD_SET_DEFAULT);
		send_request(1'b0, CMD_RESET);
	endtask

	// three-byte id, then the same command dropped for an xt host
	task automatic test_read_id();
		send_request(1'b0, CMD_READ_ID);
		write_xt_ignore(1'b1);
		send_request(1'b0, CMD_READ_ID);
		send_request(1'b1, 8'h00);
		write_xt_ignore(1'b0);
	endtask

	// mostly well-formed command sequences, with noise bytes and status reads mixed in
	task automatic test_random_traffic(input int tx_pct, input int rx_pct, input bit xt,
			input int n_items);
		int stop_at;
		int pick;
		logic [7:0] c;
		logic [7:0] p;
		write_xt_ignore(xt);
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		stop_at = requests_sent + n_items;
		while (requests_sent < stop_at) begin
			pick = $urandom_range(99);
			if (pick < 8) begin
				send_request(1'b1, 8'h00);
			end else if (pick < 20) begin
				send_request(1'b0, 8'($urandom_range(255)));
			end else begin
				c = command_menu[$urandom_range(16)];
				send_request(1'b0, c);
				if (c == CMD_TYPEMATIC || c == CMD_SCAN_SET || c == CMD_SET_LEDS) begin
					// status read while the parameter is still owed
					if ($urandom_range(9) == 0)
						send_request(1'b1, 8'h00);
					if (c == CMD_SCAN_SET && $urandom_range(2) == 0)
						send_request(1'b0, SCAN_SET_QRY);
					case (c)
						CMD_TYPEMATIC: p = $urandom_range(1) ? 8'($urandom_range(127))
							: 8'($urandom_range(255));
						CMD_SCAN_SET:  p = ($urandom_range(9) < 7) ? 8'($urandom_range(3))
							: 8'($urandom_range(255));
						default:       p = 8'($urandom_range(255));
					endcase
					send_request(1'b0, p);
				end
			end
			// occasional hold-off until the result side has drained
			if ($urandom_range(39) == 0)
				wait_for_replies();
		end
	endtask

	initial begin
		// predictor at its reset state
		kbd.awaiting   = 1'b0;
		kbd.scan_en    = 1'b1;
		kbd.rate_delay = '0;
		kbd.set_idx    = '0;
		kbd.leds       = 8'h00;
		kbd.typ_all    = 1'b1;
		kbd.brk_all    = 1'b1;
		kbd_pending    = 8'h00;
		kbd_last_sent  = RSP_SELF_TEST;
		xt_ignore_id   = 1'b0;
		tx_idle_pct    = 14;
		rx_idle_pct    = 54;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed checks under the first idle mix
		test_status_echo_resend();
		test_typematic_rate();
		test_scan_set();
		test_leds_and_mode3();
		test_defaults_and_reset();
		test_read_id();

		// random traffic: sender idles lightly, then receiver lightly, then neither idles
		test_random_traffic(14, 54, 1'b0, PHASE_ITEMS);
		test_random_traffic(54, 14, 1'b1, PHASE_ITEMS);
		test_random_traffic(0, 0, 1'b0, PHASE_ITEMS);

		wait_for_replies();

		$display("covered %0d requests (%0d status reads) and %0d checked replies",
			requests_sent, status_reads, replies_checked);
		$display("all commands and parameter paths, three idle mixes, xt id filter off and on");
		if (error_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
